// ===== hw/rtl/tap_tempo_clock_divider_assert.svh =====
// ----------------------------------------------------------------------------
// Tap tempo clock divider assertion macros
// Shared property forms used by the RTL of the tap tempo clock divider.
// ----------------------------------------------------------------------------
`ifndef TAP_TEMPO_CLOCK_DIVIDER_ASSERT_SVH
`define TAP_TEMPO_CLOCK_DIVIDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTCD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tap tempo: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TTCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tap tempo: next-cycle check failed");

`endif

// ===== hw/rtl/ttcd_pkg.sv =====
// ----------------------------------------------------------------------------
// ttcd_pkg
// Widths, register indexes, reset values and the divisor table of the tap
// tempo clock divider.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcd_pkg;

    // Tempo counters and the period fields share one width.
    localparam int QUARTER_W = 16;
    localparam int DEB_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_W     = 4;
    localparam int ITER_W    = $clog2(QUARTER_W);

    typedef logic [QUARTER_W-1:0] t_tempo;
    typedef logic [DEB_W-1:0]     t_deb;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [DIV_W-1:0]     t_div;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_DEBOUNCE_TICKS  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_INITIAL_QUARTER = t_cfg_idx'(1);

    // Values after reset.
    localparam t_deb   RESET_DEBOUNCE = t_deb'(5);
    localparam t_tempo RESET_QUARTER  = t_tempo'(15000);
    localparam t_tempo RESET_HALF     = t_tempo'(15000 / 2);

    // Half-period divisor: 2 times 2 for double time, times 3 for triplets.
    function automatic t_div div_of(input logic dbl, input logic tpl);
        t_div d;
        unique case ({dbl, tpl})
            2'b00:   d = t_div'(2);
            2'b10:   d = t_div'(4);
            2'b01:   d = t_div'(6);
            default: d = t_div'(12);
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tap_tempo_clock_divider.sv =====
// ----------------------------------------------------------------------------
// tap_tempo_clock_divider
// Tap tempo generator: debounces taps, measures the quarter-note period in
// ticks and produces a square wave at a subdivision of that period.
// ----------------------------------------------------------------------------
//  channel | handshake                   | payload
//  --------+-----------------------------+-------------------------------------
//  in      | i_in_valid / o_in_stall     | tap_level, double_switch,
//          |                             | triplet_switch
//  out     | o_out_valid / i_out_stall   | signal_out, led_out, tap_accepted,
//          |                             | quarter_period, half_period
//  cfg     | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// A tick with no tap acceptance and no switch change gives its result in the
// cycle after the beat. A tick that accepts a tap or changes a switch runs the
// shared restoring divider, one quotient bit a cycle, and then gives its result.
// Writing initial_quarter runs the same divider.
// Reset is synchronous; there is no clearing pass. A result held by a stall on
// the output keeps the input stalled until that beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tap_tempo_clock_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Tick input
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_tap_level,
    input  wire logic              i_double_switch,
    input  wire logic              i_triplet_switch,
    // Result output
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_signal_out,
    output logic                   o_led_out,
    output logic                   o_tap_accepted,
    output ttcd_pkg::t_tempo       o_quarter_period,
    output ttcd_pkg::t_tempo       o_half_period,
    // Configuration writes
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire ttcd_pkg::t_cfg_idx i_cfg_index,
    input  wire ttcd_pkg::t_tempo  i_cfg_data
);
    import ttcd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } t_state;

    // Control and tempo state.
    t_state r_state;
    t_deb   r_debounce_ticks;
    t_tempo r_quarter;
    t_tempo r_toggle;
    t_tempo r_out_count;
    t_tempo r_interval;
    t_deb   r_deb_count;
    logic   r_deb_active;
    logic   r_prev_tap;
    logic   r_prev_dbl;
    logic   r_prev_tri;
    logic   r_wave;
    logic   r_led;

    // Divider state.
    t_div              r_divisor;
    t_div              r_rem;
    t_tempo            r_quo;
    logic [ITER_W-1:0] r_iter;
    logic              r_div_cfg;

    // Output register.
    logic   r_out_valid;
    logic   r_o_wave;
    logic   r_o_led;
    logic   r_o_acc;
    t_tempo r_o_quarter;
    t_tempo r_o_half;

    // Handshakes.
    logic w_out_free;
    logic w_in_acc;
    logic w_cfg_acc;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE) || !w_out_free || i_cfg_valid;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;

    // One tick of tempo logic, everything except the half-period division.
    logic   w_changed;
    logic   w_rising;
    t_tempo w_interval_inc;
    t_deb   w_limit;
    t_deb   w_deb_inc;
    logic   w_deb_done;
    logic   w_accepted;
    logic   w_start_div;
    t_tempo n_quarter;
    t_tempo n_interval;
    t_deb   n_deb_count;
    logic   n_deb_active;
    logic   n_led;
    t_tempo w_count_inc;
    logic   w_wrap;

    always_comb begin
        w_changed      = (i_double_switch != r_prev_dbl) || (i_triplet_switch != r_prev_tri);
        w_rising       = i_tap_level && !r_prev_tap;
        w_interval_inc = (r_interval == '1) ? r_interval : r_interval + t_tempo'(1);
        w_limit        = (r_debounce_ticks == '0) ? t_deb'(1) : r_debounce_ticks;
        w_deb_inc      = r_deb_count + t_deb'(1);
        w_deb_done     = r_deb_active && !w_rising && (w_deb_inc >= w_limit);
        w_accepted     = w_deb_done && i_tap_level;
        w_start_div    = w_accepted || w_changed;

        n_quarter    = r_quarter;
        n_interval   = w_interval_inc;
        n_deb_count  = r_deb_count;
        n_deb_active = r_deb_active;
        n_led        = r_led;
        priority if (w_rising) begin
            n_deb_active = 1'b1;
            n_deb_count  = '0;
        end else if (r_deb_active) begin
            n_deb_count = w_deb_inc;
            if (w_deb_done) begin
                n_deb_active = 1'b0;
            end
            if (w_accepted) begin
                n_quarter  = w_interval_inc;
                n_interval = '0;
                n_led      = !r_led;
            end
        end else begin
            // No debounce running, so its count holds.
            n_deb_count = r_deb_count;
        end

        w_count_inc = r_out_count + t_tempo'(1);
        w_wrap      = (w_count_inc >= r_toggle);
    end

    // Shared restoring divider step: one quotient bit a cycle.
    logic [DIV_W:0] w_trial;
    logic [DIV_W:0] w_diff;
    logic           w_ge;
    logic           w_div_last;
    t_tempo         w_quotient;

    always_comb begin
        w_trial    = {r_rem, r_quo[QUARTER_W-1]};
        w_diff     = w_trial - {1'b0, r_divisor};
        w_ge       = (w_trial >= {1'b0, r_divisor});
        w_div_last = (r_iter == ITER_W'(QUARTER_W - 1));
        w_quotient = {r_quo[QUARTER_W-2:0], w_ge};
    end

    // Sequencer, tempo state and divider registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_debounce_ticks <= RESET_DEBOUNCE;
            r_quarter        <= RESET_QUARTER;
            r_toggle         <= RESET_HALF;
            r_out_count      <= '0;
            r_interval       <= '0;
            r_deb_count      <= '0;
            r_deb_active     <= 1'b0;
            r_prev_tap       <= 1'b0;
            r_prev_dbl       <= 1'b0;
            r_prev_tri       <= 1'b0;
            r_wave           <= 1'b0;
            r_led            <= 1'b0;
            r_iter           <= '0;
            r_div_cfg        <= 1'b0;
            r_divisor        <= t_div'(2);
            r_rem            <= '0;
            r_quo            <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_cfg_acc) begin
                        if (i_cfg_index == CFG_DEBOUNCE_TICKS) begin
                            r_debounce_ticks <= i_cfg_data[DEB_W-1:0];
                        end else if (i_cfg_index == CFG_INITIAL_QUARTER) begin
                            r_quarter   <= i_cfg_data;
                            r_out_count <= '0;
                            r_divisor   <= div_of(r_prev_dbl, r_prev_tri);
                            r_rem       <= '0;
                            r_quo       <= i_cfg_data;
                            r_iter      <= '0;
                            r_div_cfg   <= 1'b1;
                            r_state     <= S_DIV;
                        end
                    end else if (w_in_acc) begin
                        r_prev_dbl   <= i_double_switch;
                        r_prev_tri   <= i_triplet_switch;
                        r_prev_tap   <= i_tap_level;
                        r_interval   <= n_interval;
                        r_deb_count  <= n_deb_count;
                        r_deb_active <= n_deb_active;
                        r_quarter    <= n_quarter;
                        r_led        <= n_led;
                        if (w_start_div) begin
                            r_out_count <= '0;
                            r_divisor   <= div_of(i_double_switch, i_triplet_switch);
                            r_rem       <= '0;
                            r_quo       <= n_quarter;
                            r_iter      <= '0;
                            r_div_cfg   <= 1'b0;
                            r_state     <= S_DIV;
                        end else if (w_wrap) begin
                            r_wave      <= !r_wave;
                            r_out_count <= '0;
                        end else begin
                            r_out_count <= w_count_inc;
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
                    r_quo  <= w_quotient;
                    r_iter <= r_iter + ITER_W'(1);
                    if (w_div_last) begin
                        r_toggle <= w_quotient;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register: loaded on each tick, half period filled by the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_o_wave    <= 1'b0;
            r_o_led     <= 1'b0;
            r_o_acc     <= 1'b0;
            r_o_quarter <= RESET_QUARTER;
            r_o_half    <= RESET_HALF;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_IDLE && !w_cfg_acc && w_in_acc) begin
                r_o_wave    <= (!w_start_div && w_wrap) ? !r_wave : r_wave;
                r_o_led     <= n_led;
                r_o_acc     <= w_accepted;
                r_o_quarter <= n_quarter;
                r_o_half    <= r_toggle;
                r_out_valid <= !w_start_div;
            end
            if (r_state == S_DIV && w_div_last && !r_div_cfg) begin
                r_o_half    <= w_quotient;
                r_out_valid <= 1'b1;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_signal_out     = r_o_wave;
    assign o_led_out        = r_o_led;
    assign o_tap_accepted   = r_o_acc;
    assign o_quarter_period = r_o_quarter;
    assign o_half_period    = r_o_half;

    // Terms used by the checks below.
    logic w_chk_plain;
    logic w_chk_div_go;
    logic w_chk_div_end;
    logic w_chk_dividing;
    logic w_chk_ready_out;
    logic w_chk_div_first;

    assign w_chk_plain     = w_in_acc && !w_start_div;
    assign w_chk_div_go    = w_in_acc && w_start_div;
    assign w_chk_div_end   = (r_state == S_DIV) && w_div_last && !r_div_cfg;
    assign w_chk_dividing  = (r_state == S_DIV);
    assign w_chk_ready_out = r_out_valid && (r_state == S_IDLE);
    assign w_chk_div_first = (r_state == S_DIV) && !r_out_valid && (r_iter == '0);

    // Checks on the sequencer and the result path.
`include "tap_tempo_clock_divider_assert.svh"

    `TTCD_ASSERT_NEXT(a_plain_tick_result, i_clk, i_rst_n, w_chk_plain, w_chk_ready_out)
    `TTCD_ASSERT_NEXT(a_div_tick_runs, i_clk, i_rst_n, w_chk_div_go, w_chk_div_first)
    `TTCD_ASSERT_NEXT(a_div_end_result, i_clk, i_rst_n, w_chk_div_end, w_chk_ready_out)
    `TTCD_ASSERT_NOW(a_led_on_accept, i_clk, i_rst_n, r_out_valid && !$stable(r_o_led), r_o_acc)
    `TTCD_ASSERT_NOW(a_no_beat_while_dividing, i_clk, i_rst_n, w_chk_dividing, !w_in_acc && !w_cfg_acc)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: tap tempo clock divider testbench
// Sends timebase ticks carrying tap and switch levels, tracks the expected
// square wave, LED, accepted taps and periods tick by tick, and compares
// every result beat field by field. Register writes happen between phases.
// ----------------------------------------------------------------------------

module tb_top;

    import ttcd_pkg::*;

    // Spare register indexes that the block must ignore.
    localparam t_cfg_idx CFG_SPARE_A = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_SPARE_B = t_cfg_idx'(3);

    // Expected contents of one result beat.
    typedef struct packed {
        bit     wave;
        bit     led;
        bit     accepted;
        t_tempo quarter;
        t_tempo half;
    } t_tick_result;

    // Tempo tracker: mirrors the divider state and queues expected beats.
    class t_tempo_tracker;
        t_deb         debounce_ticks;
        t_tempo       quarter_ticks;
        t_tempo       toggle_period;
        t_tempo       output_count;
        t_tempo       interval_count;
        t_deb         debounce_count;
        bit           debounce_active;
        bit           last_tap;
        bit           last_double;
        bit           last_triplet;
        bit           wave;
        bit           led;
        t_tick_result pending[$];
        int           mismatches;
        int           checked;
        int           accepts;

        function new();
            debounce_ticks  = RESET_DEBOUNCE;
            quarter_ticks   = RESET_QUARTER;
            toggle_period   = RESET_HALF;
            output_count    = '0;
            interval_count  = '0;
            debounce_count  = '0;
            debounce_active = 1'b0;
            last_tap        = 1'b0;
            last_double     = 1'b0;
            last_triplet    = 1'b0;
            wave            = 1'b0;
            led             = 1'b0;
            mismatches      = 0;
            checked         = 0;
            accepts         = 0;
        endfunction

        // The half period uses the stored switch levels.
        function t_tempo half_for(t_tempo quarter);
            int unsigned divisor;
            divisor = 2;
            if (last_double) begin
                divisor = divisor * 2;
            end
            if (last_triplet) begin
                divisor = divisor * 3;
            end
            return t_tempo'(quarter / divisor);
        endfunction

        function void write_reg(t_cfg_idx idx, t_tempo data);
            case (idx)
                CFG_DEBOUNCE_TICKS: begin
                    debounce_ticks = data[DEB_W-1:0];
                end
                CFG_INITIAL_QUARTER: begin
                    quarter_ticks = data;
                    toggle_period = half_for(data);
                    output_count  = '0;
                end
                default: begin
                end
            endcase
        endfunction

        // One accepted tick beat advances the state and queues its result.
        function void note_tick(bit tap, bit dbl_sw, bit tpl_sw);
            bit           changed;
            bit           taken;
            t_deb         limit;
            t_tick_result r;
            changed = 1'b0;
            taken   = 1'b0;
            if (dbl_sw != last_double) begin
                last_double = dbl_sw;
                changed     = 1'b1;
            end
            if (tpl_sw != last_triplet) begin
                last_triplet = tpl_sw;
                changed      = 1'b1;
            end
            if (interval_count != '1) begin
                interval_count = interval_count + 1'b1;
            end
            // A rising edge restarts the debounce; a tap still high at its end counts.
            if (tap && !last_tap) begin
                debounce_active = 1'b1;
                debounce_count  = '0;
            end else if (debounce_active) begin
                limit          = (debounce_ticks == 0) ? t_deb'(1) : debounce_ticks;
                debounce_count = debounce_count + 1'b1;
                if (debounce_count >= limit) begin
                    debounce_active = 1'b0;
                    if (tap) begin
                        taken          = 1'b1;
                        quarter_ticks  = interval_count;
                        interval_count = '0;
                        led            = !led;
                        accepts++;
                    end
                end
            end
            last_tap = tap;
            // The output counter restarts on any tempo change, else it runs.
            if (taken || changed) begin
                toggle_period = half_for(quarter_ticks);
                output_count  = '0;
            end else begin
                output_count = output_count + 1'b1;
                if (output_count >= toggle_period) begin
                    wave         = !wave;
                    output_count = '0;
                end
            end
            r.wave     = wave;
            r.led      = led;
            r.accepted = taken;
            r.quarter  = quarter_ticks;
            r.half     = toggle_period;
            pending.push_back(r);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40) begin
                $display("ERROR: %s", msg);
            end
        endtask

        task check_tick(bit got_wave, bit got_led, bit got_acc, t_tempo got_q, t_tempo got_h);
            t_tick_result want;
            if (pending.size() == 0) begin
                report("result beat arrived with no tick waiting");
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got_wave != want.wave) begin
                report($sformatf("result %0d signal_out: got %0d, expected %0d",
                                 checked, got_wave, want.wave));
            end
            if (got_led != want.led) begin
                report($sformatf("result %0d led_out: got %0d, expected %0d",
                                 checked, got_led, want.led));
            end
            if (got_acc != want.accepted) begin
                report($sformatf("result %0d tap_accepted: got %0d, expected %0d",
                                 checked, got_acc, want.accepted));
            end
            if (got_q != want.quarter) begin
                report($sformatf("result %0d quarter_period: got %0d, expected %0d",
                                 checked, got_q, want.quarter));
            end
            if (got_h != want.half) begin
                report($sformatf("result %0d half_period: got %0d, expected %0d",
                                 checked, got_h, want.half));
            end
        endtask
    endclass

    logic     i_clk            = 1'b0;
    logic     i_rst_n          = 1'b0;
    logic     i_in_valid       = 1'b0;
    logic     i_tap_level      = 1'b0;
    logic     i_double_switch  = 1'b0;
    logic     i_triplet_switch = 1'b0;
    logic     i_out_stall      = 1'b0;
    logic     i_cfg_valid      = 1'b0;
    t_cfg_idx i_cfg_index      = CFG_DEBOUNCE_TICKS;
    t_tempo   i_cfg_data       = '0;
    logic     o_in_stall;
    logic     o_out_valid;
    logic     o_signal_out;
    logic     o_led_out;
    logic     o_tap_accepted;
    t_tempo   o_quarter_period;
    t_tempo   o_half_period;
    logic     o_cfg_ready;

    t_tempo_tracker board = new();
    bit           sw_dbl      = 1'b0;
    bit           sw_tpl      = 1'b0;
    bit           in_idling   = 1'b1;
    bit           out_idling  = 1'b1;
    int           ticks_sent  = 0;
    int           cfg_writes  = 0;

    tap_tempo_clock_divider dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_tap_level      (i_tap_level),
        .i_double_switch  (i_double_switch),
        .i_triplet_switch (i_triplet_switch),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_signal_out     (o_signal_out),
        .o_led_out        (o_led_out),
        .o_tap_accepted   (o_tap_accepted),
        .o_quarter_period (o_quarter_period),
        .o_half_period    (o_half_period),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Clock with a period of two time units.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on the run, far above the slowest correct run.
    initial begin
        #1000000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Result side: random stall bursts while enabled.
    initial begin
        forever begin
            @(posedge i_clk);
            if (out_idling && $urandom_range(0, 11) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Every result beat taken at this edge is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_tick(o_signal_out, o_led_out, o_tap_accepted,
                             o_quarter_period, o_half_period);
        end
    end

    // Sends one tick beat with the current switch levels.
    task automatic send_tick(input bit tap);
        if (in_idling && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_tap_level      <= tap;
        i_double_switch  <= sw_dbl;
        i_triplet_switch <= sw_tpl;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_tick(tap, sw_dbl, sw_tpl);
        ticks_sent++;
    endtask

    task automatic send_ticks(input bit tap, input int count);
        repeat (count) send_tick(tap);
    endtask

    // A register write; valid stays high until end_cfg so writes run back to back.
    task automatic write_cfg(input t_cfg_idx idx, input t_tempo data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, data);
        cfg_writes++;
    endtask

    task automatic end_cfg();
        i_cfg_valid <= 1'b0;
    endtask

    // Stops sending and waits until every expected beat has come back.
    task automatic drain(input int settle);
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Mostly clean presses with random gaps, plus early releases, bounces and noise.
    task automatic run_taps(input int target);
        int stop;
        int deb;
        int kind;
        stop = ticks_sent + target;
        while (ticks_sent < stop) begin
            deb  = (board.debounce_ticks == 0) ? 1 : int'(board.debounce_ticks);
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 7) == 0) begin
                sw_dbl = 1'($urandom_range(0, 1));
                sw_tpl = 1'($urandom_range(0, 1));
            end
            if ($urandom_range(0, 3) == 0) begin
                send_ticks(1'b0, $urandom_range(20, 120));
            end else begin
                send_ticks(1'b0, $urandom_range(0, 12));
            end
            case (kind)
                7: begin
                    send_ticks(1'b1, $urandom_range(1, deb));
                end
                8: begin
                    send_ticks(1'b1, $urandom_range(1, deb));
                    send_tick(1'b0);
                    send_ticks(1'b1, deb + 1);
                end
                9: begin
                    repeat ($urandom_range(1, 8)) begin
                        sw_dbl = 1'($urandom_range(0, 1));
                        sw_tpl = 1'($urandom_range(0, 1));
                        send_tick(1'($urandom_range(0, 1)));
                    end
                end
                default: begin
                    send_ticks(1'b1, deb + 1 + $urandom_range(0, 3));
                end
            endcase
            send_tick(1'b0);
        end
    endtask

    // Main sequence.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Switch combinations, a clean press, an early release and a bounce.
        send_ticks(1'b0, 2);
        sw_dbl = 1'b1;
        send_tick(1'b0);
        sw_tpl = 1'b1;
        send_tick(1'b0);
        sw_dbl = 1'b0;
        send_tick(1'b0);
        sw_tpl = 1'b0;
        send_tick(1'b0);
        send_ticks(1'b1, 6);
        send_tick(1'b0);
        send_ticks(1'b1, 3);
        send_tick(1'b0);
        send_ticks(1'b1, 2);
        send_tick(1'b0);
        send_ticks(1'b1, 6);
        send_tick(1'b0);

        // Zero debounce, the smallest quarter and writes to spare indexes.
        drain(4);
        write_cfg(CFG_DEBOUNCE_TICKS, 16'hFF00);
        write_cfg(CFG_INITIAL_QUARTER, 16'h0001);
        write_cfg(CFG_SPARE_A, 16'hFFFF);
        write_cfg(CFG_SPARE_B, 16'h5A5A);
        end_cfg();
        sw_dbl = 1'b1;
        sw_tpl = 1'b1;
        send_ticks(1'b0, 3);
        send_ticks(1'b1, 2);
        send_tick(1'b0);
        send_ticks(1'b1, 2);
        send_tick(1'b0);

        // Random phases, each with its own register setting.
        for (int phase = 0; phase < 4; phase++) begin
            drain(4);
            case (phase)
                0: begin
                    write_cfg(CFG_DEBOUNCE_TICKS, 16'd1);
                    write_cfg(CFG_INITIAL_QUARTER, 16'hFFFF);
                end
                1: begin
                    write_cfg(CFG_DEBOUNCE_TICKS, 16'd255);
                    write_cfg(CFG_INITIAL_QUARTER, t_tempo'($urandom_range(1, 65535)));
                end
                2: begin
                    write_cfg(CFG_DEBOUNCE_TICKS, t_tempo'($urandom_range(2, 6)));
                    write_cfg(CFG_INITIAL_QUARTER, t_tempo'($urandom_range(1, 200)));
                end
                default: begin
                    write_cfg(CFG_DEBOUNCE_TICKS, t_tempo'($urandom_range(1, 8)));
                    write_cfg(CFG_INITIAL_QUARTER, t_tempo'($urandom_range(1, 65535)));
                end
            endcase
            end_cfg();
            in_idling  = (phase != 2);
            out_idling = (phase != 2);
            run_taps((phase == 1) ? 160 : 120);
        end

        // Last part, no idling: a clean press, then both switches on and random taps.
        drain(4);
        write_cfg(CFG_DEBOUNCE_TICKS, t_tempo'($urandom_range(1, 4)));
        end_cfg();
        in_idling  = 1'b0;
        out_idling = 1'b0;
        sw_dbl     = 1'b0;
        sw_tpl     = 1'b0;
        send_ticks(1'b0, 40);
        send_ticks(1'b1, int'(board.debounce_ticks) + 1);
        send_tick(1'b0);
        sw_dbl = 1'b1;
        sw_tpl = 1'b1;
        send_ticks(1'b0, 4);
        run_taps(60);

        drain(24);
        $display("Sent %0d ticks: %0d taps accepted, %0d register writes.",
                 ticks_sent, board.accepts, cfg_writes);
        $display("Compared %0d result beats, %0d mismatches.",
                 board.checked, board.mismatches);
        if (board.mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
